// File: rtl/sjc_pkg.sv
package sjc_pkg;

  // Command queue between the classifier and the byte expander
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Escape selector codes
  localparam logic [1:0] MODE_NEW = 2'd0;
  localparam logic [1:0] MODE_OLD = 2'd1;
  localparam logic [1:0] MODE_NEC = 2'd2;

  // Sound mark codes for kana widening
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_VOICED = 2'd1;
  localparam logic [1:0] MARK_SEMI   = 2'd2;

  // Byte values
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_AT     = 8'd64;
  localparam logic [7:0] CH_B      = 8'd66;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_J      = 8'd74;
  localparam logic [7:0] CH_K      = 8'd75;
  localparam logic [7:0] CH_H      = 8'd72;
  localparam logic [7:0] CH_VOICED = 8'd222;
  localparam logic [7:0] CH_SEMI   = 8'd223;

  // Operation slots of one command, in emission order
  localparam int OP_KI   = 0;  // kanji-in before slot A
  localparam int OP_A    = 1;  // two bytes from the pending lead or kana
  localparam int OP_ESCB = 2;  // escape before slot B
  localparam int OP_B    = 3;  // one or two bytes from the current byte
  localparam int OP_KO   = 4;  // kanji-out at end of text
  localparam int OP_NUM  = 5;

  typedef struct packed {
    logic       a_ki;
    logic       a_valid;
    logic [7:0] a1;
    logic [7:0] a2;
    logic       b_esc;
    logic       b_ko;     // escape before B is kanji-out, else kanji-in
    logic       b_valid;
    logic       b_two;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       c_ko;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= 8'd129 && b <= 8'd159) || (b >= 8'd224 && b <= 8'd239);
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return (b >= 8'd64 && b <= 8'd126) || (b >= 8'd128 && b <= 8'd252);
  endfunction

  function automatic logic is_kana(input logic [7:0] b);
    return b >= 8'd161 && b <= 8'd223;
  endfunction

  function automatic logic takes_maru(input logic [7:0] b);
    return b >= 8'd202 && b <= 8'd206;
  endfunction

  function automatic logic takes_nigori(input logic [7:0] b);
    return (b >= 8'd182 && b <= 8'd196) || takes_maru(b) || b == 8'd179;
  endfunction

  // Full-width Shift-JIS code of each half-width kana, lead in the high byte
  function automatic logic [15:0] kana_entry(input logic [5:0] idx);
    logic [15:0] e;
    unique case (idx)
      6'd0:  e = {8'd129, 8'd66};
      6'd1:  e = {8'd129, 8'd117};
      6'd2:  e = {8'd129, 8'd118};
      6'd3:  e = {8'd129, 8'd65};
      6'd4:  e = {8'd129, 8'd69};
      6'd5:  e = {8'd131, 8'd146};
      6'd6:  e = {8'd131, 8'd64};
      6'd7:  e = {8'd131, 8'd66};
      6'd8:  e = {8'd131, 8'd68};
      6'd9:  e = {8'd131, 8'd70};
      6'd10: e = {8'd131, 8'd72};
      6'd11: e = {8'd131, 8'd131};
      6'd12: e = {8'd131, 8'd133};
      6'd13: e = {8'd131, 8'd135};
      6'd14: e = {8'd131, 8'd98};
      6'd15: e = {8'd129, 8'd91};
      6'd16: e = {8'd131, 8'd65};
      6'd17: e = {8'd131, 8'd67};
      6'd18: e = {8'd131, 8'd69};
      6'd19: e = {8'd131, 8'd71};
      6'd20: e = {8'd131, 8'd73};
      6'd21: e = {8'd131, 8'd74};
      6'd22: e = {8'd131, 8'd76};
      6'd23: e = {8'd131, 8'd78};
      6'd24: e = {8'd131, 8'd80};
      6'd25: e = {8'd131, 8'd82};
      6'd26: e = {8'd131, 8'd84};
      6'd27: e = {8'd131, 8'd86};
      6'd28: e = {8'd131, 8'd88};
      6'd29: e = {8'd131, 8'd90};
      6'd30: e = {8'd131, 8'd92};
      6'd31: e = {8'd131, 8'd94};
      6'd32: e = {8'd131, 8'd96};
      6'd33: e = {8'd131, 8'd99};
      6'd34: e = {8'd131, 8'd101};
      6'd35: e = {8'd131, 8'd103};
      6'd36: e = {8'd131, 8'd105};
      6'd37: e = {8'd131, 8'd106};
      6'd38: e = {8'd131, 8'd107};
      6'd39: e = {8'd131, 8'd108};
      6'd40: e = {8'd131, 8'd109};
      6'd41: e = {8'd131, 8'd110};
      6'd42: e = {8'd131, 8'd113};
      6'd43: e = {8'd131, 8'd116};
      6'd44: e = {8'd131, 8'd119};
      6'd45: e = {8'd131, 8'd122};
      6'd46: e = {8'd131, 8'd125};
      6'd47: e = {8'd131, 8'd126};
      6'd48: e = {8'd131, 8'd128};
      6'd49: e = {8'd131, 8'd129};
      6'd50: e = {8'd131, 8'd130};
      6'd51: e = {8'd131, 8'd132};
      6'd52: e = {8'd131, 8'd134};
      6'd53: e = {8'd131, 8'd136};
      6'd54: e = {8'd131, 8'd137};
      6'd55: e = {8'd131, 8'd138};
      6'd56: e = {8'd131, 8'd139};
      6'd57: e = {8'd131, 8'd140};
      6'd58: e = {8'd131, 8'd141};
      6'd59: e = {8'd131, 8'd143};
      6'd60: e = {8'd131, 8'd147};
      6'd61: e = {8'd129, 8'd74};
      default: e = {8'd129, 8'd75};  // last entry, also the clamp
    endcase
    return e;
  endfunction

  // Map a Shift-JIS pair to a JIS row/cell pair
  function automatic logic [15:0] sjis_to_jis(input logic [7:0] c1, input logic [7:0] c2);
    logic       adj;
    logic [7:0] row_off;
    logic [7:0] cell_off;
    logic [7:0] diff;
    logic [7:0] j1;
    logic [7:0] j2;
    adj      = c2 < 8'd159;
    row_off  = (c1 < 8'd160) ? 8'd112 : 8'd176;
    cell_off = adj ? ((c2 > 8'd127) ? 8'd32 : 8'd31) : 8'd126;
    diff     = c1 - row_off;
    j1       = {diff[6:0], 1'b0} - {7'd0, adj};
    j2       = c2 - cell_off;
    return {j1, j2};
  endfunction

  // Widen a half-width kana, merge a sound mark, return the JIS pair
  function automatic logic [15:0] kana_widen(input logic [7:0] k, input logic [1:0] mark);
    logic [7:0]  d;
    logic [15:0] e;
    logic [7:0]  s1;
    logic [7:0]  s2;
    d  = k - 8'd161;
    e  = kana_entry(d[5:0]);
    s1 = e[15:8];
    s2 = e[7:0];
    if (mark == MARK_VOICED) begin
      if ((s2 >= 8'd74 && s2 <= 8'd103) || (s2 >= 8'd110 && s2 <= 8'd122)) begin
        s2 = s2 + 8'd1;
      end else if (s1 == 8'd131 && s2 == 8'd69) begin
        s2 = 8'd148;
      end
    end else if (mark == MARK_SEMI && s2 >= 8'd110 && s2 <= 8'd122) begin
      s2 = s2 + 8'd2;
    end
    return sjis_to_jis(s1, s2);
  endfunction

endpackage

// File: rtl/sjc_front.sv
module sjc_front
  import sjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       cmd
);

  logic       two_byte_mode;
  logic       two_byte_mode_next;
  logic       lead_valid;
  logic       lead_valid_next;
  logic [7:0] lead_value;
  logic [7:0] lead_value_next;
  logic       kana_valid;
  logic       kana_valid_next;
  logic [7:0] kana_value;
  logic [7:0] kana_value_next;

  logic        accept;
  logic        m;
  logic        consumed;
  logic [1:0]  mark;
  logic [15:0] pair_a;
  logic [15:0] kana_a;
  logic [15:0] kana_b;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_byte == CH_VOICED && takes_nigori(kana_value)) begin
      mark = MARK_VOICED;
    end else if (in_byte == CH_SEMI && takes_maru(kana_value)) begin
      mark = MARK_SEMI;
    end else begin
      mark = MARK_NONE;
    end
  end

  assign pair_a = sjis_to_jis(lead_value, in_byte);
  assign kana_a = kana_widen(kana_value, mark);
  assign kana_b = kana_widen(in_byte, MARK_NONE);

  always_comb begin
    m               = two_byte_mode;
    consumed        = 1'b0;
    cmd             = '0;
    lead_valid_next = lead_valid;
    lead_value_next = lead_value;
    kana_valid_next = kana_valid;
    kana_value_next = kana_value;

    // resolve the pending lead or kana
    if (lead_valid) begin
      lead_valid_next = 1'b0;
      consumed        = 1'b1;
      cmd.a_valid     = 1'b1;
      if (is_trail(in_byte)) begin
        cmd.a_ki       = !m;
        m              = 1'b1;
        {cmd.a1, cmd.a2} = pair_a;
      end else begin
        cmd.a1 = lead_value;
        cmd.a2 = in_byte;
      end
    end else if (kana_valid) begin
      kana_valid_next  = 1'b0;
      cmd.a_valid      = 1'b1;
      cmd.a_ki         = !m;
      m                = 1'b1;
      {cmd.a1, cmd.a2} = kana_a;
      consumed         = (mark != MARK_NONE);
    end

    // classify the current byte
    if (!consumed) begin
      priority if (is_lead(in_byte)) begin
        if (in_last) begin
          cmd.b_valid = 1'b1;
          cmd.b1      = in_byte;
        end else begin
          lead_valid_next = 1'b1;
          lead_value_next = in_byte;
        end
      end else if (is_kana(in_byte)) begin
        if (in_last) begin
          cmd.b_valid      = 1'b1;
          cmd.b_two        = 1'b1;
          cmd.b_esc        = !m;
          cmd.b_ko         = 1'b0;
          m                = 1'b1;
          {cmd.b1, cmd.b2} = kana_b;
        end else begin
          kana_valid_next = 1'b1;
          kana_value_next = in_byte;
        end
      end else begin
        cmd.b_valid = 1'b1;
        cmd.b1      = in_byte;
        cmd.b_esc   = m;
        cmd.b_ko    = 1'b1;
        m           = 1'b0;
      end
    end

    if (in_last) begin
      cmd.c_ko = m;
      m        = 1'b0;
    end
    two_byte_mode_next = m;
  end

  // drop items that only store a pending byte
  assign push = accept && (cmd.a_valid || cmd.b_valid || cmd.c_ko);

  always_ff @(posedge clk) begin
    if (rst) begin
      two_byte_mode <= 1'b0;
      lead_valid    <= 1'b0;
      kana_valid    <= 1'b0;
      lead_value    <= '0;
      kana_value    <= '0;
    end else if (accept) begin
      two_byte_mode <= two_byte_mode_next;
      lead_valid    <= lead_valid_next;
      kana_valid    <= kana_valid_next;
      lead_value    <= lead_value_next;
      kana_value    <= kana_value_next;
    end
  end

endmodule

// File: rtl/sjc_queue.sv
module sjc_queue
  import sjc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t q_stat
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sjc_back.sv
module sjc_back
  import sjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  cmd_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [OP_NUM-1:0] done;
  logic [1:0]        cnt;

  logic [OP_NUM-1:0] present;
  logic [OP_NUM-1:0] remain;
  logic [OP_NUM-1:0] cur;
  logic [OP_NUM-1:0] remain_after;
  logic              is_nec;
  logic [7:0]        ki_byte;
  logic [7:0]        ko_byte;
  logic [1:0]        esc_len;
  logic [7:0]        sel_byte;
  logic [1:0]        sel_len;
  logic              step;
  logic              op_end;
  logic              cmd_end;

  assign present = {head.c_ko, head.b_valid, head.b_esc, head.a_valid, head.a_ki};
  assign remain  = present & ~done;

  // lowest pending slot goes first
  always_comb begin
    cur = '0;
    priority if (remain[OP_KI])   cur[OP_KI]   = 1'b1;
    else if (remain[OP_A])        cur[OP_A]    = 1'b1;
    else if (remain[OP_ESCB])     cur[OP_ESCB] = 1'b1;
    else if (remain[OP_B])        cur[OP_B]    = 1'b1;
    else if (remain[OP_KO])       cur[OP_KO]   = 1'b1;
    else                          cur          = '0;
  end

  assign is_nec  = (mode == MODE_NEC);
  assign esc_len = is_nec ? 2'd2 : 2'd3;

  always_comb begin
    unique case (cnt)
      2'd0:    ki_byte = CH_ESC;
      2'd1:    ki_byte = is_nec ? CH_K : CH_DOLLAR;
      default: ki_byte = (mode == MODE_OLD) ? CH_AT : CH_B;
    endcase
    unique case (cnt)
      2'd0:    ko_byte = CH_ESC;
      2'd1:    ko_byte = is_nec ? CH_H : CH_LPAREN;
      default: ko_byte = CH_J;
    endcase
  end

  always_comb begin
    priority if (cur[OP_KI]) begin
      sel_byte = ki_byte;
      sel_len  = esc_len;
    end else if (cur[OP_A]) begin
      sel_byte = (cnt == 2'd0) ? head.a1 : head.a2;
      sel_len  = 2'd2;
    end else if (cur[OP_ESCB]) begin
      sel_byte = head.b_ko ? ko_byte : ki_byte;
      sel_len  = esc_len;
    end else if (cur[OP_B]) begin
      sel_byte = (cnt == 2'd0) ? head.b1 : head.b2;
      sel_len  = head.b_two ? 2'd2 : 2'd1;
    end else begin
      sel_byte = ko_byte;
      sel_len  = esc_len;
    end
  end

  assign step         = !q_stat.empty && (!out_valid || out_ready);
  assign op_end       = (cnt == sel_len - 2'd1);
  assign remain_after = remain & ~cur;
  assign cmd_end      = op_end && (remain_after == '0);
  assign pop          = step && cmd_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
      done      <= '0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        cnt       <= op_end ? 2'd0 : cnt + 2'd1;
        if (cmd_end) begin
          done <= '0;
        end else if (op_end) begin
          done <= done | cur;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= sel_byte;
      out_last <= cmd_end;
    end
  end

endmodule

// File: rtl/sjis_to_iso2022jp_converter.sv
// With the queue empty and the output free, an accepted request's command is written to
//   a queue slot, and its first byte is then registered onto out_byte.
// Throughput: one input request per cycle while the 4-deep command queue has room;
//   one output byte per cycle while a command is queued and the output is not stalled.
// Reset (rst, synchronous, active high) clears the queue, the output register,
//   the pending lead/kana flags, two-byte mode, and selects the new-JIS escapes.
module sjis_to_iso2022jp_converter
  import sjc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] out_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // Escape selector; the unused code maps to new-JIS
  logic [1:0] mode;

  // Front classifies each request and resolves pending bytes into a command;
  // the back expands commands into escapes and data bytes.
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NEW;
    end else if (cfg_valid && cfg_ready) begin
      mode <= (out_mode == MODE_OLD || out_mode == MODE_NEC) ? out_mode : MODE_NEW;
    end
  end

  sjc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Hold commands so the front keeps accepting while output is stalled
  sjc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  sjc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef NO_ASSERTIONS
  // Queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // A new output byte appears only when a command was waiting
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!q_stat.empty))
    else $error("output byte without a queued command");

  // Reset drops the output register
  a_rst_out: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // No pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");
`endif

endmodule
